// File: rtl/gars_pkg.sv
package gars_pkg;

	// Reset value of the sample period register (seconds * 65536)
	localparam logic [15:0] PERIOD_RESET = 16'd131;

	// Angle accumulators, in the order the shared multiplier visits them
	localparam int ACC_NUM = 6;

	// Spread lanes: roll and pitch windows
	localparam int LANE_ROLL  = 0;
	localparam int LANE_PITCH = 1;
	localparam int LANES      = 2;

	// Integer square root: result bits and first trial bit
	localparam int          ROOT_BITS = 16;
	localparam logic [15:0] ROOT_MSB  = 16'h8000;

	// Cycles the mean / variance chain needs once the window sums are final
	localparam int MEAN_CYCLES = 5;

	typedef enum logic [2:0] {
		ACC_RING  = 3'd0,
		ACC_RAMP  = 3'd1,
		ACC_AVOID = 3'd2,
		ACC_ROLL  = 3'd3,
		ACC_PITCH = 3'd4,
		ACC_YAW   = 3'd5
	} acc_sel_t;

	// One input request, lowest field in the lowest bits
	typedef struct packed {
		logic               avoid_track_enable;
		logic               ramp_track_enable;
		logic               ring_track_enable;
		logic signed [15:0] yaw_rate;
		logic signed [15:0] pitch_rate;
		logic signed [15:0] roll_rate;
		logic               gyro_ready;
	} in_item_t;

	// One result request, lowest field in the lowest bits
	typedef struct packed {
		logic        [15:0] pitch_spread;
		logic        [15:0] roll_spread;
		logic signed [31:0] avoid_yaw_angle;
		logic signed [31:0] ramp_pitch_angle;
		logic signed [31:0] ring_turn_angle;
		logic signed [31:0] yaw_angle;
		logic signed [31:0] pitch_angle;
		logic signed [31:0] roll_angle;
	} out_item_t;

	// Commands from the sequencer to the datapath
	typedef struct packed {
		logic     in_load;
		logic     acc_mul;
		acc_sel_t acc_sel;
		logic     win_write;
		logic     rd_en;
		logic     root_clear;
		logic     root_step;
		logic     out_load;
	} cmd_t;

endpackage

// File: rtl/gars_dpath.sv
module gars_dpath #(
	parameter int WINDOW_SIZE = 16,
	localparam int AW = $clog2(WINDOW_SIZE)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gars_pkg::cmd_t       cmd,
	input  logic [AW-1:0]        rd_addr,
	input  gars_pkg::in_item_t   in_data,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_data,
	output logic                 gyro_ready,
	output gars_pkg::out_item_t  out_data
);
	import gars_pkg::*;

	// floor(2^32 / N); quotient estimate is exact or one low, fixed by one compare
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / WINDOW_SIZE);
	localparam int SUM_W  = 16 + AW;
	localparam int NQ_W   = 31 + AW + 1;
	localparam int MR_W   = SUM_W + AW + 1;

	logic [15:0] period_q;
	in_item_t    in_q;

	// ---------------- angle integrators ----------------
	logic        [47:0] acc_q [ACC_NUM];
	logic signed [15:0] prev_pitch_q, prev_yaw_q;
	logic signed [15:0] mul_rate;
	logic signed [32:0] mul_prod;
	logic signed [32:0] prod_q;
	acc_sel_t           prod_sel_q;
	logic               prod_valid_q;
	logic               acc_gate;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			period_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			in_q <= in_data;
		end
	end

	assign gyro_ready = in_q.gyro_ready;

	always_comb begin
		case (cmd.acc_sel)
			ACC_RING:  mul_rate = prev_yaw_q;
			ACC_RAMP:  mul_rate = prev_pitch_q;
			ACC_AVOID: mul_rate = prev_yaw_q;
			ACC_ROLL:  mul_rate = in_q.roll_rate;
			ACC_PITCH: mul_rate = in_q.pitch_rate;
			ACC_YAW:   mul_rate = in_q.yaw_rate;
			default:   mul_rate = '0;
		endcase
	end

	assign mul_prod = mul_rate * $signed({1'b0, period_q});

	always_ff @(posedge clk) begin
		prod_q     <= mul_prod;
		prod_sel_q <= cmd.acc_sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_valid_q <= 1'b0;
		end else begin
			prod_valid_q <= cmd.acc_mul;
		end
	end

	// gated integrators clear while their enable is low
	always_comb begin
		case (prod_sel_q)
			ACC_RING:  acc_gate = in_q.ring_track_enable;
			ACC_RAMP:  acc_gate = in_q.ramp_track_enable;
			ACC_AVOID: acc_gate = in_q.avoid_track_enable;
			default:   acc_gate = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ACC_NUM; i++) begin
				acc_q[i] <= '0;
			end
		end else if (prod_valid_q) begin
			for (int i = 0; i < ACC_NUM; i++) begin
				if (prod_sel_q == acc_sel_t'(i)) begin
					acc_q[i] <= acc_gate ? acc_q[i] + {{15{prod_q[32]}}, prod_q} : '0;
				end
			end
		end
	end

	// ---------------- rate windows ----------------
	logic signed [15:0] roll_mem  [WINDOW_SIZE];
	logic signed [15:0] pitch_mem [WINDOW_SIZE];
	logic [WINDOW_SIZE-1:0] win_valid_q;
	logic [AW-1:0]          pos_q;

	always_ff @(posedge clk) begin
		if (cmd.win_write) begin
			roll_mem[pos_q]  <= in_q.roll_rate;
			pitch_mem[pos_q] <= in_q.pitch_rate;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_valid_q  <= '0;
			pos_q        <= '0;
			prev_pitch_q <= '0;
			prev_yaw_q   <= '0;
		end else if (cmd.win_write) begin
			win_valid_q[pos_q] <= 1'b1;
			pos_q        <= (pos_q == AW'(WINDOW_SIZE - 1)) ? '0 : pos_q + 1'b1;
			prev_pitch_q <= in_q.pitch_rate;
			prev_yaw_q   <= in_q.yaw_rate;
		end
	end

	// ---------------- window walk: read, square, divide by N, sum ----------------
	logic signed [15:0] rdata_s1 [LANES];
	logic               vbit_s1;
	logic               v_s1, v_s2, v_s3;
	logic signed [15:0] x_s2 [LANES];
	logic        [30:0] sq_s2 [LANES];
	logic signed [15:0] x_s3 [LANES];
	logic        [30:0] sq_s3 [LANES];
	logic        [30:0] q0_s3 [LANES];
	logic        [31:0] sqsum_q [LANES];
	logic signed [SUM_W-1:0] sum_q [LANES];

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_s1[LANE_ROLL]  <= roll_mem[rd_addr];
			rdata_s1[LANE_PITCH] <= pitch_mem[rd_addr];
			vbit_s1              <= win_valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [15:0] x;
		logic signed [31:0] sq;
		logic        [62:0] qp;
		for (int l = 0; l < LANES; l++) begin
			x        = vbit_s1 ? rdata_s1[l] : 16'sd0;
			sq       = x * x;
			x_s2[l]  <= x;
			sq_s2[l] <= sq[30:0];
			qp       = 63'(sq_s2[l]) * 63'(RECIP);
			q0_s3[l] <= qp[62:32];
			sq_s3[l] <= sq_s2[l];
			x_s3[l]  <= x_s2[l];
		end
	end

	always_ff @(posedge clk) begin
		logic [NQ_W-1:0] rem;
		logic [30:0]     q;
		if (cmd.in_load) begin
			for (int l = 0; l < LANES; l++) begin
				sqsum_q[l] <= '0;
				sum_q[l]   <= '0;
			end
		end else if (v_s3) begin
			for (int l = 0; l < LANES; l++) begin
				rem = NQ_W'(sq_s3[l]) - NQ_W'(q0_s3[l]) * NQ_W'(WINDOW_SIZE);
				q   = q0_s3[l] + 31'(rem >= NQ_W'(WINDOW_SIZE));
				sqsum_q[l] <= sqsum_q[l] + 32'(q);
				sum_q[l]   <= sum_q[l] + SUM_W'(x_s3[l]);
			end
		end
	end

	// ---------------- mean, variance (free-running on settled sums) ----------------
	logic [SUM_W-1:0] mag_q  [LANES];
	logic [SUM_W-1:0] mq0_q  [LANES];
	logic [15:0]      mean_q [LANES];
	logic [31:0]      meansq_q [LANES];
	logic [30:0]      diff_q [LANES];

	always_ff @(posedge clk) begin
		logic [SUM_W+31:0] mp;
		logic [MR_W-1:0]   rem;
		logic [SUM_W-1:0]  mq;
		logic [32:0]       dfull;
		for (int l = 0; l < LANES; l++) begin
			mag_q[l]    <= sum_q[l][SUM_W-1] ? SUM_W'(-sum_q[l]) : SUM_W'(sum_q[l]);
			mp          = (SUM_W+32)'(mag_q[l]) * (SUM_W+32)'(RECIP);
			mq0_q[l]    <= mp[SUM_W+31:32];
			rem         = MR_W'(mag_q[l]) - MR_W'(mq0_q[l]) * MR_W'(WINDOW_SIZE);
			mq          = mq0_q[l] + SUM_W'(rem >= MR_W'(WINDOW_SIZE));
			mean_q[l]   <= mq[15:0];
			meansq_q[l] <= mean_q[l] * mean_q[l];
			dfull       = {1'b0, sqsum_q[l]} - {1'b0, meansq_q[l]};
			diff_q[l]   <= dfull[32] ? '0 : dfull[30:0];
		end
	end

	// ---------------- bit-serial square root ----------------
	logic [15:0] root_q [LANES];
	logic [15:0] mask_q;

	always_ff @(posedge clk) begin
		logic [15:0] cand;
		logic [31:0] csq;
		if (cmd.root_clear) begin
			mask_q <= ROOT_MSB;
			for (int l = 0; l < LANES; l++) begin
				root_q[l] <= '0;
			end
		end else if (cmd.root_step) begin
			mask_q <= mask_q >> 1;
			for (int l = 0; l < LANES; l++) begin
				cand = root_q[l] | mask_q;
				csq  = cand * cand;
				if (csq <= {1'b0, diff_q[l]}) begin
					root_q[l] <= cand;
				end
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data.roll_angle       <= acc_q[ACC_ROLL][47:16];
			out_data.pitch_angle      <= acc_q[ACC_PITCH][47:16];
			out_data.yaw_angle        <= acc_q[ACC_YAW][47:16];
			out_data.ring_turn_angle  <= acc_q[ACC_RING][47:16];
			out_data.ramp_pitch_angle <= acc_q[ACC_RAMP][47:16];
			out_data.avoid_yaw_angle  <= acc_q[ACC_AVOID][47:16];
			out_data.roll_spread      <= root_q[LANE_ROLL];
			out_data.pitch_spread     <= root_q[LANE_PITCH];
		end
	end

endmodule

// File: rtl/gars_ctrl.sv
module gars_ctrl #(
	parameter int WINDOW_SIZE = 16,
	localparam int AW = $clog2(WINDOW_SIZE)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  logic           gyro_ready,
	output gars_pkg::cmd_t cmd,
	output logic [AW-1:0]  rd_addr
);
	import gars_pkg::*;

	localparam int CNT_MAX = (WINDOW_SIZE + 2 > ROOT_BITS) ? WINDOW_SIZE + 2 : ROOT_BITS;
	localparam int CNT_W   = $clog2(CNT_MAX + 1);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_ACC   = 7'b0000010,
		S_WRITE = 7'b0000100,
		S_WALK  = 7'b0001000,
		S_MEAN  = 7'b0010000,
		S_ROOT  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign rd_addr   = cnt_q[AW-1:0];

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q + 1'b1;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cnt_d = '0;
				if (in_valid) begin
					cmd.in_load = 1'b1;
					state_d     = S_ACC;
				end
			end
			S_ACC: begin
				cmd.acc_sel = acc_sel_t'(cnt_q[2:0]);
				if (!gyro_ready) begin
					cnt_d   = '0;
					state_d = S_WALK;
				end else if (cnt_q == CNT_W'(ACC_NUM)) begin
					state_d = S_WRITE;
				end else begin
					cmd.acc_mul = 1'b1;
				end
			end
			S_WRITE: begin
				cmd.win_write = 1'b1;
				cnt_d         = '0;
				state_d       = S_WALK;
			end
			S_WALK: begin
				cmd.rd_en = (cnt_q < CNT_W'(WINDOW_SIZE));
				if (cnt_q == CNT_W'(WINDOW_SIZE + 2)) begin
					cnt_d   = '0;
					state_d = S_MEAN;
				end
			end
			S_MEAN: begin
				if (cnt_q == CNT_W'(MEAN_CYCLES - 1)) begin
					cmd.root_clear = 1'b1;
					cnt_d          = '0;
					state_d        = S_ROOT;
				end
			end
			S_ROOT: begin
				cmd.root_step = 1'b1;
				if (cnt_q == CNT_W'(ROOT_BITS - 1)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/gyro_angle_and_rate_spread_unit.sv
// Gyro angle integrator with windowed roll/pitch rate spread.
//
// s_axis: one gyro sample per request. cfg: write of the sample period
// (seconds * 65536), taken whenever cfg_valid is high; write it only while
// the unit is idle. m_axis: one result request per sample, carrying the six
// integrated angles and the two spreads.
//
// Sequence: a sample with gyro_ready set is integrated, written to the
// window, walked, reduced to mean and variance, rooted and handed off
// before the next acceptance; m_axis_tvalid is registered and rises once
// the result is loaded. A sample with gyro_ready clear skips integration
// and window write. The time taken is set by the shared rate * period
// multiplier (six passes), the window walk (one entry a cycle plus a
// 3-deep pipe), the mean/variance chain and the 16-step square root.
//
// Reset clears all accumulators, the previous rates, the window position
// and the per-entry valid bits (unwritten entries read as zero); the period
// returns to 131. A finished result sits in the output register while a new
// sample is accepted and processed; if m_axis_tready is still low when the
// next result is ready, the unit holds it and stops taking input.
module gyro_angle_and_rate_spread_unit #(
	parameter int WINDOW_SIZE = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// sample in
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [0] gyro_ready, [16:1] roll_rate, [32:17] pitch_rate, [48:33] yaw_rate,
	// [49] ring_track_enable, [50] ramp_track_enable, [51] avoid_track_enable,
	// [55:52] zero
	input  logic [55:0]  s_axis_tdata,
	// result out
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [31:0] roll_angle, [63:32] pitch_angle, [95:64] yaw_angle,
	// [127:96] ring_turn_angle, [159:128] ramp_pitch_angle,
	// [191:160] avoid_yaw_angle, [207:192] roll_spread, [223:208] pitch_spread
	output logic [223:0] m_axis_tdata,
	// sample period register write
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);
	import gars_pkg::*;

	localparam int AW = $clog2(WINDOW_SIZE);

	cmd_t          cmd;
	logic [AW-1:0] rd_addr;
	logic          gyro_ready;
	in_item_t      in_item;
	out_item_t     out_item;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	assign in_item      = in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);
	assign m_axis_tdata = out_item;

	// sequencer: accept, integrate, write window, walk, mean, root, hand off
	gars_ctrl #(
		.WINDOW_SIZE(WINDOW_SIZE)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.gyro_ready(gyro_ready),
		.cmd       (cmd),
		.rd_addr   (rd_addr)
	);

	// accumulators, window memories, spread arithmetic, result register
	gars_dpath #(
		.WINDOW_SIZE(WINDOW_SIZE)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.in_data   (in_item),
		.cfg_we    (cfg_valid),
		.cfg_data  (cfg_data),
		.gyro_ready(gyro_ready),
		.out_data  (out_item)
	);

endmodule
